### hw/rtl/tbfe_pkg.sv
// Shared types, sizes and codes for the three-band FIR equaliser.
// Used by tbfe_mac, the core and the testbench; depends on nothing else.
package tbfe_pkg;

   // Block sizes.
   localparam int NUM_TAPS     = 32;
   localparam int MAX_CHANNELS = 8;

   // Derived index and counter widths.
   localparam int TAP_IW     = $clog2(NUM_TAPS);
   localparam int CNT_W      = $clog2(NUM_TAPS + 1);
   localparam int CH_IW      = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int LINE_DEPTH = MAX_CHANNELS * NUM_TAPS;
   localparam int LINE_AW    = $clog2(LINE_DEPTH);

   // Arithmetic widths: tap times gain, weight, product and accumulator.
   localparam int SAMPLE_W   = 16;
   localparam int GAIN_W     = 16;
   localparam int BP_W       = SAMPLE_W + GAIN_W + 1;
   localparam int W_W        = BP_W + 2;
   localparam int PROD_W     = SAMPLE_W + W_W;
   localparam int ACC_W      = PROD_W + $clog2(NUM_TAPS);
   localparam int RND_SHIFT  = 27;
   localparam int SH_W       = ACC_W + 1 - RND_SHIFT;

   // Word operation codes.
   typedef enum logic [1:0] {
      MODE_FILTER   = 2'd0,
      MODE_LOAD_TAP = 2'd1,
      MODE_CLEAR    = 2'd2,
      MODE_NONE     = 2'd3
   } mode_type;

   // Tap table selection.
   typedef enum logic [1:0] {
      BAND_LOW  = 2'd0,
      BAND_MID  = 2'd1,
      BAND_HIGH = 2'd2,
      BAND_NONE = 2'd3
   } band_type;

   // Configuration register indexes.
   typedef enum logic [1:0] {
      CSR_CHANNELS_IN_USE = 2'd0,
      CSR_LOW_GAIN        = 2'd1,
      CSR_MID_GAIN        = 2'd2,
      CSR_HIGH_GAIN       = 2'd3
   } csr_index_type;

   // Input word.
   typedef struct packed {
      logic [1:0]                 mode;
      logic [2:0]                 channel;
      logic signed [SAMPLE_W-1:0] sample_in;
      logic [1:0]                 band;
      logic [4:0]                 tap_index;
      logic signed [SAMPLE_W-1:0] coefficient;
   } req_payload_type;

   // Result word.
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample_out;
      logic                       channel_rejected;
   } rsp_payload_type;

   // Band gains handed to the multiply-accumulate unit.
   typedef struct packed {
      logic [GAIN_W-1:0] low;
      logic [GAIN_W-1:0] mid;
      logic [GAIN_W-1:0] high;
   } gains_type;

   // Per-tap control issued alongside the memory read addresses.
   typedef struct packed {
      logic issue;
      logic first;
      logic last;
      logic line_ok;
   } mac_ctrl_type;

endpackage

### hw/rtl/tbfe_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// Stand-alone; no package needed.
module tbfe_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/tbfe_mac.sv
// Pipelined multiply-accumulate unit: band weights, tap product, sum, rounding.
// Depends on tbfe_pkg for widths, gains_type and mac_ctrl_type.
module tbfe_mac import tbfe_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  mac_ctrl_type               ctrl,
   input  gains_type                  gains,
   input  logic [SAMPLE_W-1:0]        line_q,
   input  logic [SAMPLE_W-1:0]        low_q,
   input  logic [SAMPLE_W-1:0]        mid_q,
   input  logic [SAMPLE_W-1:0]        high_q,
   output logic                       mac_done,
   output logic signed [SAMPLE_W-1:0] mac_result
);

   localparam logic signed [SH_W-1:0] SAT_HI = SH_W'(32767);
   localparam logic signed [SH_W-1:0] SAT_LO = -SH_W'(32768);

   mac_ctrl_type ctrl1_ff, ctrl2_ff, ctrl3_ff, ctrl4_ff;
   logic         done_ff, done_in, result_ok_ff;

   logic signed [BP_W-1:0]     bp_low_ff, bp_mid_ff, bp_high_ff;
   logic signed [BP_W-1:0]     bp_low_in, bp_mid_in, bp_high_in;
   logic signed [SAMPLE_W-1:0] line2_ff, line2_in, line3_ff;
   logic signed [W_W-1:0]      w_ff, w_in;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;
   logic signed [ACC_W:0]      rnd;
   logic signed [SH_W-1:0]     shifted;
   logic signed [SAMPLE_W-1:0] result_ff, result_in;

   // Band taps times their gains; positions past the fill count read as zero.
   always_comb begin
      bp_low_in  = BP_W'(signed'(low_q))  * BP_W'(signed'({1'b0, gains.low}));
      bp_mid_in  = BP_W'(signed'(mid_q))  * BP_W'(signed'({1'b0, gains.mid}));
      bp_high_in = BP_W'(signed'(high_q)) * BP_W'(signed'({1'b0, gains.high}));
      line2_in   = ctrl1_ff.line_ok ? signed'(line_q) : '0;
   end

   // Tap weight, then sample times weight, then running sum.
   always_comb begin
      w_in    = W_W'(bp_low_ff) + W_W'(bp_mid_ff) + W_W'(bp_high_ff);
      prod_in = PROD_W'(line3_ff) * PROD_W'(w_ff);
      if (ctrl4_ff.first) begin
         acc_in = ACC_W'(prod_ff);
      end else begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end
   end

   // Round half up at bit 27, then saturate to the sample range.
   always_comb begin
      rnd     = (ACC_W + 1)'(acc_ff) + (ACC_W + 1)'(64'sd1 <<< (RND_SHIFT - 1));
      shifted = SH_W'(rnd >>> RND_SHIFT);
      if (shifted > SAT_HI) begin
         result_in = SAMPLE_W'(SAT_HI);
      end else if (shifted < SAT_LO) begin
         result_in = SAMPLE_W'(SAT_LO);
      end else begin
         result_in = SAMPLE_W'(shifted);
      end
      done_in = ctrl4_ff.issue && ctrl4_ff.last;
   end

   // Control pipeline, aligned with the data stages. The done flag is raised
   // once the rounded result has reached its register.
   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl1_ff     <= '0;
         ctrl2_ff     <= '0;
         ctrl3_ff     <= '0;
         ctrl4_ff     <= '0;
         done_ff      <= 1'b0;
         result_ok_ff <= 1'b0;
      end else begin
         ctrl1_ff     <= ctrl;
         ctrl2_ff     <= ctrl1_ff;
         ctrl3_ff     <= ctrl2_ff;
         ctrl4_ff     <= ctrl3_ff;
         done_ff      <= done_in;
         result_ok_ff <= done_ff;
      end
   end

   // Data pipeline; the sum only moves on valid taps and the result only on the last one.
   always_ff @(posedge clock) begin
      bp_low_ff  <= bp_low_in;
      bp_mid_ff  <= bp_mid_in;
      bp_high_ff <= bp_high_in;
      line2_ff   <= line2_in;
      line3_ff   <= line2_ff;
      w_ff       <= w_in;
      prod_ff    <= prod_in;
      if (ctrl4_ff.issue) begin
         acc_ff <= acc_in;
      end
      if (done_ff) begin
         result_ff <= result_in;
      end
   end

   assign mac_done   = result_ok_ff;
   assign mac_result = result_ff;

endmodule

### hw/rtl/three_band_fir_equalizer_core.sv
// Top level of the three-band FIR equaliser: sequencer, delay line and tap stores.
// Depends on tbfe_pkg, tbfe_ram and tbfe_mac.
//
// Multichannel FIR equaliser with one shared multiply-accumulate unit. A filter
// word (mode 0) writes the sample into its channel's circular delay line and then
// steps the MAC through all NUM_TAPS taps, one tap a cycle, through the memory
// reads, four MAC pipeline stages and the rounding register; the result is then
// loaded into the output register once that is free, and only then is the next
// word taken; req_ready is low meanwhile. Tap loads (mode 1) and delay line
// clears (mode 2) act at acceptance and give no result; a clear only zeroes the
// per-channel fill counts, so it is immediate. A word for a channel at or above
// channels_in_use gives sample_out zero with channel_rejected set. Taps must be
// loaded before they are used. The result sits in an output register, so new
// words are taken while it waits. Configuration is to be written by the user
// only while the block is idle; the block itself does not enforce this.
module three_band_fir_equalizer_core import tbfe_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_data,
   input  logic            csr_wr_en,
   input  logic [1:0]      csr_index,
   input  logic [15:0]     csr_wdata
);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_WRITE = 5'b00010,
      S_ISSUE = 5'b00100,
      S_DRAIN = 5'b01000,
      S_HOLD  = 5'b10000
   } state_type;

   state_type        state_ff, state_in;
   req_payload_type  item_ff;
   logic             reject_ff, reject_in;
   logic [3:0]       chan_use_ff;
   gains_type        gains_ff;

   logic [TAP_IW-1:0]  ptr_ff [MAX_CHANNELS];
   logic [CNT_W-1:0]   cnt_ff [MAX_CHANNELS];
   logic [TAP_IW-1:0]  idx_ff, idx_in;
   logic [TAP_IW-1:0]  rd_pos_ff, rd_pos_in;
   logic [LINE_AW-1:0] base_ff, base_in;

   logic               rsp_valid_ff;
   rsp_payload_type    rsp_data_ff;
   logic               rsp_free, rsp_load;

   logic               req_accept;
   logic [CH_IW-1:0]   ch_idx;
   logic [TAP_IW-1:0]  new_ptr;
   logic               tap_wr_ok;
   logic               line_wr;
   logic [LINE_AW-1:0] line_rd_addr;
   mac_ctrl_type       mac_ctrl;
   logic               mac_done;
   logic signed [SAMPLE_W-1:0] mac_result;
   logic [SAMPLE_W-1:0] line_q, low_q, mid_q, high_q;
   logic               wr_low, wr_mid, wr_high;

   assign req_ready  = (state_ff == S_IDLE);
   assign req_accept = req_valid && req_ready;
   assign rsp_free   = !rsp_valid_ff || rsp_ready;
   assign ch_idx     = CH_IW'(item_ff.channel);

   // Next write position of the channel's circular line.
   assign new_ptr = (ptr_ff[ch_idx] == TAP_IW'(NUM_TAPS - 1)) ? '0 : ptr_ff[ch_idx] + 1'b1;

   // Channel range check on the incoming word.
   assign reject_in = ({1'b0, req_data.channel} >= chan_use_ff) ||
                      (32'(req_data.channel) >= MAX_CHANNELS);

   // Tap table write decode, done in the cycle the word is accepted.
   always_comb begin
      tap_wr_ok = req_accept && (mode_type'(req_data.mode) == MODE_LOAD_TAP) &&
                  (32'(req_data.tap_index) < NUM_TAPS);
      wr_low  = 1'b0;
      wr_mid  = 1'b0;
      wr_high = 1'b0;
      unique case (band_type'(req_data.band))
         BAND_LOW:  wr_low  = tap_wr_ok;
         BAND_MID:  wr_mid  = tap_wr_ok;
         BAND_HIGH: wr_high = tap_wr_ok;
         default:   ;
      endcase
   end

   // Sequencer.
   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      rd_pos_in = rd_pos_ff;
      base_in   = base_ff;
      rsp_load  = 1'b0;
      line_wr   = 1'b0;
      mac_ctrl  = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_accept && (mode_type'(req_data.mode) == MODE_FILTER)) begin
               state_in = reject_in ? S_HOLD : S_WRITE;
            end
         end
         S_WRITE: begin
            line_wr   = 1'b1;
            base_in   = LINE_AW'(ch_idx) * LINE_AW'(NUM_TAPS);
            idx_in    = '0;
            rd_pos_in = new_ptr;
            state_in  = S_ISSUE;
         end
         S_ISSUE: begin
            mac_ctrl.issue   = 1'b1;
            mac_ctrl.first   = (idx_ff == '0);
            mac_ctrl.last    = (idx_ff == TAP_IW'(NUM_TAPS - 1));
            mac_ctrl.line_ok = (CNT_W'(idx_ff) < cnt_ff[ch_idx]);
            idx_in    = idx_ff + 1'b1;
            rd_pos_in = (rd_pos_ff == '0) ? TAP_IW'(NUM_TAPS - 1) : rd_pos_ff - 1'b1;
            if (mac_ctrl.last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (mac_done) begin
               if (rsp_free) begin
                  rsp_load = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  state_in = S_HOLD;
               end
            end
         end
         S_HOLD: begin
            if (rsp_free) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign line_rd_addr = base_ff + LINE_AW'(rd_pos_ff);

   // Sequencer registers and the word latched at acceptance.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      idx_ff    <= idx_in;
      rd_pos_ff <= rd_pos_in;
      base_ff   <= base_in;
      if (req_accept) begin
         item_ff   <= req_data;
         reject_ff <= reject_in;
      end
   end

   // Per-channel write position and fill count; a clear empties every line.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < MAX_CHANNELS; c++) begin
            ptr_ff[c] <= '0;
            cnt_ff[c] <= '0;
         end
      end else if (req_accept && (mode_type'(req_data.mode) == MODE_CLEAR)) begin
         for (int c = 0; c < MAX_CHANNELS; c++) begin
            cnt_ff[c] <= '0;
         end
      end else if (line_wr) begin
         ptr_ff[ch_idx] <= new_ptr;
         if (cnt_ff[ch_idx] != CNT_W'(NUM_TAPS)) begin
            cnt_ff[ch_idx] <= cnt_ff[ch_idx] + 1'b1;
         end
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         chan_use_ff   <= 4'd2;
         gains_ff.low  <= 16'd1365;
         gains_ff.mid  <= 16'd1365;
         gains_ff.high <= 16'd1365;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_CHANNELS_IN_USE: chan_use_ff   <= csr_wdata[3:0];
            CSR_LOW_GAIN:        gains_ff.low  <= csr_wdata;
            CSR_MID_GAIN:        gains_ff.mid  <= csr_wdata;
            CSR_HIGH_GAIN:       gains_ff.high <= csr_wdata;
            default:             ;
         endcase
      end
   end

   // Output register; holds the result word until it is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (rsp_load) begin
         rsp_data_ff.sample_out       <= reject_ff ? '0 : mac_result;
         rsp_data_ff.channel_rejected <= reject_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Delay lines of all channels in one memory.
   tbfe_ram #(.WIDTH(SAMPLE_W), .DEPTH(LINE_DEPTH)) u_line_ram (
      .clock   (clock),
      .wr_en   (line_wr),
      .wr_addr (base_in + LINE_AW'(new_ptr)),
      .wr_data (item_ff.sample_in),
      .rd_addr (line_rd_addr),
      .rd_data (line_q)
   );

   // Band tap tables.
   tbfe_ram #(.WIDTH(SAMPLE_W), .DEPTH(NUM_TAPS)) u_low_ram (
      .clock   (clock),
      .wr_en   (wr_low),
      .wr_addr (TAP_IW'(req_data.tap_index)),
      .wr_data (req_data.coefficient),
      .rd_addr (idx_ff),
      .rd_data (low_q)
   );

   tbfe_ram #(.WIDTH(SAMPLE_W), .DEPTH(NUM_TAPS)) u_mid_ram (
      .clock   (clock),
      .wr_en   (wr_mid),
      .wr_addr (TAP_IW'(req_data.tap_index)),
      .wr_data (req_data.coefficient),
      .rd_addr (idx_ff),
      .rd_data (mid_q)
   );

   tbfe_ram #(.WIDTH(SAMPLE_W), .DEPTH(NUM_TAPS)) u_high_ram (
      .clock   (clock),
      .wr_en   (wr_high),
      .wr_addr (TAP_IW'(req_data.tap_index)),
      .wr_data (req_data.coefficient),
      .rd_addr (idx_ff),
      .rd_data (high_q)
   );

   // Shared multiply-accumulate unit.
   tbfe_mac u_mac (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (mac_ctrl),
      .gains      (gains_ff),
      .line_q     (line_q),
      .low_q      (low_q),
      .mid_q      (mid_q),
      .high_q     (high_q),
      .mac_done   (mac_done),
      .mac_result (mac_result)
   );

endmodule

### sim/tb_three_band_fir_equalizer_core.sv
// Self-checking testbench for the three-band FIR equaliser core.
// Depends on tbfe_pkg and three_band_fir_equalizer_core; a behavioural
// predictor in this file produces the expected filtered words.
`timescale 1ns / 100ps

module tb_three_band_fir_equalizer_core;
   import tbfe_pkg::*;

   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int SETTLE_WAIT  = 64;
   localparam int SEGMENT_SIZE = 165;

   logic            clock;
   logic            reset;
   logic            req_valid;
   logic            req_ready;
   req_payload_type req_data;
   logic            rsp_valid;
   logic            rsp_ready;
   rsp_payload_type rsp_data;
   logic            csr_wr_en;
   logic [1:0]      csr_index;
   logic [15:0]     csr_wdata;

   // Predictor state: delay lines, tap tables and the register copies.
   logic signed [15:0] line_store [MAX_CHANNELS][NUM_TAPS];
   logic signed [15:0] tap_store [3][NUM_TAPS];
   logic [3:0]         active_channels;
   logic [15:0]        band_gain [3];

   rsp_payload_type pending_outputs [$];
   rsp_payload_type oldest_output;

   int unsigned send_idle_pct;
   int unsigned recv_stall_pct;
   int unsigned cycle_count;
   int unsigned error_count;
   int unsigned words_sent;
   int unsigned results_checked;
   int unsigned rejected_results;
   int unsigned saturated_results;
   int unsigned settings_applied;

   three_band_fir_equalizer_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Free-running clock, 10 ns period.
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Result side back-pressure, changed on the falling edge.
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: run exceeded %0d cycles, %0d results still awaited",
                  $time, CYCLE_LIMIT, pending_outputs.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Compare every result word taken with the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_outputs.size() == 0) begin
            $display("%0t: unexpected result word: sample_out %0d, rejected %0b",
                     $time, rsp_data.sample_out, rsp_data.channel_rejected);
            error_count++;
         end else begin
            oldest_output = pending_outputs.pop_front();
            results_checked++;
            if (rsp_data.sample_out !== oldest_output.sample_out) begin
               $display("%0t: sample_out mismatch: expected %0d, actual %0d",
                        $time, oldest_output.sample_out, rsp_data.sample_out);
               error_count++;
            end
            if (rsp_data.channel_rejected !== oldest_output.channel_rejected) begin
               $display("%0t: channel_rejected mismatch: expected %0b, actual %0b",
                        $time, oldest_output.channel_rejected,
                        rsp_data.channel_rejected);
               error_count++;
            end
         end
      end
   end

   // Apply one accepted word to the predictor and queue any result it gives.
   function automatic void equalise_word(input req_payload_type word);
      longint          acc;
      longint          weight;
      longint          rounded;
      int unsigned     ch;
      rsp_payload_type result;
      ch = word.channel;
      case (word.mode)
         MODE_FILTER: begin
            result.channel_rejected = 1'b0;
            result.sample_out       = '0;
            if ({1'b0, word.channel} >= active_channels) begin
               result.channel_rejected = 1'b1;
               rejected_results++;
            end else begin
               for (int i = NUM_TAPS - 1; i > 0; i--)
                  line_store[ch][i] = line_store[ch][i-1];
               line_store[ch][0] = word.sample_in;
               acc = 0;
               for (int i = 0; i < NUM_TAPS; i++) begin
                  weight = 0;
                  for (int b = 0; b < 3; b++)
                     weight += longint'(tap_store[b][i]) * longint'(band_gain[b]);
                  acc += longint'(line_store[ch][i]) * weight;
               end
               // Round half upwards, then clamp to the 16-bit sample range.
               rounded = (acc + 64'sd67108864) >>> RND_SHIFT;
               if (rounded > 32767) begin
                  result.sample_out = 16'sh7fff;
                  saturated_results++;
               end else if (rounded < -32768) begin
                  result.sample_out = 16'sh8000;
                  saturated_results++;
               end else begin
                  result.sample_out = 16'(rounded);
               end
            end
            pending_outputs.push_back(result);
         end
         MODE_LOAD_TAP: begin
            if (word.band != BAND_NONE)
               tap_store[word.band][word.tap_index] = word.coefficient;
         end
         MODE_CLEAR: begin
            foreach (line_store[c, i]) line_store[c][i] = '0;
         end
         default: ;
      endcase
   endfunction

   function automatic req_payload_type build_word(input mode_type mode,
                                                  input logic [2:0] channel,
                                                  input logic signed [15:0] sample,
                                                  input band_type band,
                                                  input logic [4:0] tap_index,
                                                  input logic signed [15:0] coef);
      req_payload_type word;
      word.mode        = mode;
      word.channel     = channel;
      word.sample_in   = sample;
      word.band        = band;
      word.tap_index   = tap_index;
      word.coefficient = coef;
      return word;
   endfunction

   // Random word: every field random, then shaped by the kind chosen.
   function automatic req_payload_type random_word();
      req_payload_type word;
      int unsigned     pick;
      word.mode        = 2'($urandom);
      word.channel     = 3'($urandom);
      word.sample_in   = 16'($urandom);
      word.band        = 2'($urandom);
      word.tap_index   = 5'($urandom);
      word.coefficient = $signed(16'($urandom)) >>> $urandom_range(6);
      pick = $urandom_range(99);
      if (pick < 75) begin
         word.mode = MODE_FILTER;
         if ($urandom_range(7) == 0) begin
            case ($urandom_range(3))
               0: word.sample_in = 16'sh7fff;
               1: word.sample_in = 16'sh8000;
               2: word.sample_in = 16'sh0000;
               default: word.sample_in = 16'shffff;
            endcase
         end
      end else if (pick < 90) begin
         word.mode = MODE_LOAD_TAP;
         if ($urandom_range(9) != 0)
            word.band = band_type'($urandom_range(2));
         else
            word.band = BAND_NONE;
      end else if (pick < 94) begin
         word.mode = MODE_CLEAR;
      end else begin
         word.mode = MODE_NONE;
      end
      return word;
   endfunction

   // Present one word and hold it until the core takes it.
   task automatic send_word(input req_payload_type word);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= word;
      do @(posedge clock); while (!req_ready);
      words_sent++;
      equalise_word(word);
      @(negedge clock);
   endtask

   // Stop sending, wait for all predicted results, then let the core settle.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_outputs.size() != 0) @(negedge clock);
      repeat (SETTLE_WAIT) @(negedge clock);
   endtask

   // Write all four registers while the core is idle.
   task automatic apply_settings(input logic [3:0] channels, input logic [15:0] low,
                                 input logic [15:0] mid, input logic [15:0] high);
      drain_results();
      csr_wr_en <= 1'b1;
      csr_index <= CSR_CHANNELS_IN_USE;
      csr_wdata <= {12'd0, channels};
      @(negedge clock);
      csr_index <= CSR_LOW_GAIN;
      csr_wdata <= low;
      @(negedge clock);
      csr_index <= CSR_MID_GAIN;
      csr_wdata <= mid;
      @(negedge clock);
      csr_index <= CSR_HIGH_GAIN;
      csr_wdata <= high;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      active_channels = channels;
      band_gain[0]    = low;
      band_gain[1]    = mid;
      band_gain[2]    = high;
      settings_applied++;
   endtask

   // Before any tap is written, only rejected channels may be filtered.
   task automatic test_rejection_at_reset();
      send_word(build_word(MODE_FILTER, 3'd2, 16'sd1234, BAND_LOW, 5'd0, 16'sd0));
      send_word(build_word(MODE_FILTER, 3'd7, 16'sh8000, BAND_LOW, 5'd0, 16'sd0));
      send_word(build_word(MODE_NONE, 3'd0, 16'sh7fff, BAND_HIGH, 5'd31, 16'sd5));
   endtask

   // Fill every tap of every band; the first two taps hold the extremes.
   task automatic test_tap_loading();
      logic signed [15:0] coef;
      for (int b = 0; b < 3; b++) begin
         for (int i = 0; i < NUM_TAPS; i++) begin
            if (i == 0)
               coef = 16'sh7fff;
            else if (i == 1)
               coef = 16'sh8000;
            else
               coef = $signed(16'($urandom)) >>> $urandom_range(4);
            send_word(build_word(MODE_LOAD_TAP, 3'(i), 16'sd0, band_type'(b),
                                 5'(i), coef));
         end
      end
      // A load to the unused band must leave the tables alone.
      send_word(build_word(MODE_LOAD_TAP, 3'd0, 16'sd0, BAND_NONE, 5'd0, 16'sh5555));
   endtask

   // Full gains with full-scale taps drive the output into both limits.
   task automatic test_saturation();
      apply_settings(4'd8, 16'hffff, 16'hffff, 16'hffff);
      send_word(build_word(MODE_CLEAR, 3'd0, 16'sd0, BAND_LOW, 5'd0, 16'sd0));
      send_word(build_word(MODE_FILTER, 3'd0, 16'sh7fff, BAND_LOW, 5'd0, 16'sd0));
      send_word(build_word(MODE_CLEAR, 3'd0, 16'sd0, BAND_LOW, 5'd0, 16'sd0));
      send_word(build_word(MODE_FILTER, 3'd7, 16'sh8000, BAND_LOW, 5'd0, 16'sd0));
      send_word(build_word(MODE_FILTER, 3'd7, 16'sh7fff, BAND_LOW, 5'd0, 16'sd0));
   endtask

   // Unity gains and one half-weight tap put results exactly on a half.
   task automatic test_rounding();
      apply_settings(4'd8, 16'd4096, 16'd4096, 16'd4096);
      send_word(build_word(MODE_LOAD_TAP, 3'd0, 16'sd0, BAND_LOW, 5'd0, 16'sd16384));
      send_word(build_word(MODE_LOAD_TAP, 3'd0, 16'sd0, BAND_MID, 5'd0, 16'sd0));
      send_word(build_word(MODE_LOAD_TAP, 3'd0, 16'sd0, BAND_HIGH, 5'd0, 16'sd0));
      send_word(build_word(MODE_CLEAR, 3'd0, 16'sd0, BAND_LOW, 5'd0, 16'sd0));
      send_word(build_word(MODE_FILTER, 3'd0, 16'sd1, BAND_LOW, 5'd0, 16'sd0));
      send_word(build_word(MODE_CLEAR, 3'd0, 16'sd0, BAND_LOW, 5'd0, 16'sd0));
      send_word(build_word(MODE_FILTER, 3'd0, -16'sd1, BAND_LOW, 5'd0, 16'sd0));
      send_word(build_word(MODE_CLEAR, 3'd0, 16'sd0, BAND_LOW, 5'd0, 16'sd0));
      send_word(build_word(MODE_FILTER, 3'd3, 16'sd3, BAND_LOW, 5'd0, 16'sd0));
      send_word(build_word(MODE_CLEAR, 3'd0, 16'sd0, BAND_LOW, 5'd0, 16'sd0));
      send_word(build_word(MODE_FILTER, 3'd3, -16'sd3, BAND_LOW, 5'd0, 16'sd0));
   endtask

   // Channel limit at zero, one and above the number of channels built.
   task automatic test_channel_limits();
      apply_settings(4'd0, 16'd1365, 16'd1365, 16'd1365);
      send_word(build_word(MODE_FILTER, 3'd0, 16'sd100, BAND_LOW, 5'd0, 16'sd0));
      apply_settings(4'd1, 16'd1365, 16'd1365, 16'd1365);
      send_word(build_word(MODE_FILTER, 3'd0, 16'sd100, BAND_LOW, 5'd0, 16'sd0));
      send_word(build_word(MODE_FILTER, 3'd1, 16'sd100, BAND_LOW, 5'd0, 16'sd0));
      apply_settings(4'd15, 16'd1365, 16'd1365, 16'd1365);
      send_word(build_word(MODE_FILTER, 3'd7, -16'sd100, BAND_LOW, 5'd0, 16'sd0));
   endtask

   // Random traffic in segments, each with its own settings and one of four idling patterns.
   task automatic test_random_traffic();
      req_payload_type word;
      int unsigned     counted;
      for (int seg = 0; seg < 8; seg++) begin
         case (seg)
            0: apply_settings(4'd8, 16'd1365, 16'd1365, 16'd1365);
            1: apply_settings(4'd3, 16'($urandom), 16'($urandom), 16'($urandom));
            2: apply_settings(4'd15, 16'hffff, 16'd0, 16'hffff);
            3: apply_settings(4'd1, 16'd0, 16'd0, 16'd0);
            4: apply_settings(4'd0, 16'($urandom), 16'($urandom), 16'($urandom));
            5: apply_settings(4'($urandom_range(1, 8)), 16'($urandom),
                              16'($urandom), 16'($urandom));
            6: apply_settings(4'd8, 16'd4096, 16'd4096, 16'd4096);
            default: apply_settings(4'($urandom), 16'($urandom >> 18),
                                    16'($urandom >> 18), 16'($urandom >> 18));
         endcase
         case (seg % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
            default: begin send_idle_pct = 9; recv_stall_pct = 9; end
         endcase
         counted = 0;
         while (counted < SEGMENT_SIZE) begin
            word = random_word();
            send_word(word);
            // Words the core simply drops do not count towards the segment.
            if (word.mode != MODE_NONE &&
                !(word.mode == MODE_LOAD_TAP && word.band == BAND_NONE))
               counted++;
         end
      end
   endtask

   // Main sequence.
   initial begin
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_data          = '0;
      csr_wr_en         = 1'b0;
      csr_index         = CSR_CHANNELS_IN_USE;
      csr_wdata         = '0;
      send_idle_pct     = 0;
      recv_stall_pct    = 0;
      words_sent        = 0;
      rejected_results  = 0;
      saturated_results = 0;
      settings_applied  = 0;
      active_channels   = 4'd2;
      band_gain[0]      = 16'd1365;
      band_gain[1]      = 16'd1365;
      band_gain[2]      = 16'd1365;
      foreach (line_store[c, i]) line_store[c][i] = '0;
      foreach (tap_store[b, i]) tap_store[b][i] = '0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_rejection_at_reset();
      test_tap_loading();
      test_saturation();
      test_rounding();
      test_channel_limits();
      test_random_traffic();
      drain_results();

      $display("Sent %0d words under %0d register settings and four idling patterns.",
               words_sent, settings_applied);
      $display("Checked %0d results, %0d on rejected channels and %0d at a limit.",
               results_checked, rejected_results, saturated_results);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

### filelist.f
hw/rtl/tbfe_pkg.sv
hw/rtl/tbfe_ram.sv
hw/rtl/tbfe_mac.sv
hw/rtl/three_band_fir_equalizer_core.sv
sim/tb_three_band_fir_equalizer_core.sv
